>>> design/jsu_pkg.sv
// shared types, constants and helper functions of the json string unescaper
package jsu_pkg;

  // widths
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 14;
  localparam int POS_W       = 14;
  localparam int COUNT_W     = 13;
  localparam int CP_W        = 16;
  localparam int NB_W        = 2;

  // defaults for top level parameters
  localparam int MAX_CAPACITY_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // reset value of the capacity register
  localparam logic [CFG_W-1:0] CAP_RESET = 14'd8192;

  // characters
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;

  // utf-8 encoding constants
  localparam logic [CP_W-1:0]   UTF_1B_MAX = 16'h007F;
  localparam logic [CP_W-1:0]   UTF_2B_MAX = 16'h07FF;
  localparam logic [BYTE_W-1:0] UTF_LEAD2  = 8'hC0;
  localparam logic [BYTE_W-1:0] UTF_LEAD3  = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF_CONT   = 8'h80;
  localparam logic [5:0]        UTF_MASK6  = 6'h3F;

  // decode phase
  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_HEX3   = 3'd5
  } phase_t;

  // one run of results caused by one item
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [NB_W-1:0]   nb;
    logic              eos;
    logic              failed;
    logic [POS_W-1:0]  base;
  } run_t;

  // hex digit value, msb set when the byte is a hex digit
  function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // single byte escapes, msb set when the character is one of them
  function automatic logic [BYTE_W:0] esc_simple(input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] r;
    case (b)
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_N:      r = {1'b1, CH_LF};
      CH_R:      r = {1'b1, CH_CR};
      CH_T:      r = {1'b1, CH_TAB};
      CH_B:      r = {1'b1, CH_BS};
      CH_F:      r = {1'b1, CH_FF};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/jsu_front.sv
// front end: takes input items, runs the escape decoder, builds result runs
module jsu_front #(
  parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [jsu_pkg::CFG_W-1:0]   cfg_out_capacity,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jsu_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last,
  input  logic                        q_full,
  output logic                        q_push,
  output jsu_pkg::run_t               q_run
);
  import jsu_pkg::*;

  localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
  localparam int CMP_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;

  logic [CFG_W-1:0]  cap_r;
  phase_t            phase_r, phase_nxt;
  logic [CP_W-1:0]   cp_r, cp_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              failed_r, failed_nxt;

  logic              accept;
  logic [CMP_W-1:0]  cfg_ext, max_c, cap_eff;
  logic [CMP_W:0]    pos_ext;
  logic              room1, room2, room4;
  logic [BYTE_W:0]   esc;
  logic [4:0]        hv;
  logic [CP_W-1:0]   cp_full;
  logic              fail_set, fail_end;
  logic [NB_W-1:0]   nb;
  logic [BYTE_W-1:0] b0, b1, b2;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // effective capacity and room checks
  assign cfg_ext = CMP_W'(cap_r);
  assign max_c   = CMP_W'(MAX_CAPACITY);
  assign cap_eff = (cfg_ext > max_c) ? max_c : cfg_ext;
  assign pos_ext = (CMP_W + 1)'(pos_r);
  assign room1   = (pos_ext + (CMP_W + 1)'(1)) < {1'b0, cap_eff};
  assign room2   = (pos_ext + (CMP_W + 1)'(2)) < {1'b0, cap_eff};
  assign room4   = (pos_ext + (CMP_W + 1)'(4)) < {1'b0, cap_eff};

  assign esc     = esc_simple(in_byte);
  assign hv      = hex_value(in_byte);
  assign cp_full = {cp_r[CP_W-5:0], hv[3:0]};

  // decode one byte
  always_comb begin
    phase_nxt = phase_r;
    cp_nxt    = cp_r;
    fail_set  = 1'b0;
    nb        = '0;
    b0        = '0;
    b1        = '0;
    b2        = '0;
    if (!failed_r) begin
      case (phase_r)
        PH_ESC: begin
          phase_nxt = PH_NORMAL;
          if (esc[BYTE_W]) begin
            if (room1) begin
              nb = 2'd1;
              b0 = esc[BYTE_W-1:0];
            end else begin
              fail_set = 1'b1;
            end
          end else if (in_byte == CH_U) begin
            if (room4) begin
              phase_nxt = PH_HEX0;
              cp_nxt    = '0;
            end else begin
              fail_set = 1'b1;
            end
          end else if (room2) begin
            nb = 2'd2;
            b0 = CH_BSLASH;
            b1 = in_byte;
          end else begin
            fail_set = 1'b1;
          end
        end
        PH_HEX0, PH_HEX1, PH_HEX2: begin
          if (!hv[4]) begin
            fail_set = 1'b1;
          end else begin
            cp_nxt    = cp_full;
            phase_nxt = phase_t'(phase_r + 3'd1);
          end
        end
        PH_HEX3: begin
          if (!hv[4]) begin
            fail_set = 1'b1;
          end else begin
            cp_nxt    = cp_full;
            phase_nxt = PH_NORMAL;
            if (cp_full <= UTF_1B_MAX) begin
              nb = 2'd1;
              b0 = cp_full[7:0];
            end else if (cp_full <= UTF_2B_MAX) begin
              nb = 2'd2;
              b0 = UTF_LEAD2 | {3'b000, cp_full[10:6]};
              b1 = UTF_CONT | {2'b00, cp_full[5:0] & UTF_MASK6};
            end else begin
              nb = 2'd3;
              b0 = UTF_LEAD3 | {4'b0000, cp_full[15:12]};
              b1 = UTF_CONT | {2'b00, cp_full[11:6] & UTF_MASK6};
              b2 = UTF_CONT | {2'b00, cp_full[5:0] & UTF_MASK6};
            end
          end
        end
        default: begin
          phase_nxt = PH_NORMAL;
          if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else if (room1) begin
            nb = 2'd1;
            b0 = in_byte;
          end else begin
            fail_set = 1'b1;
          end
        end
      endcase
      if (fail_set) begin
        phase_nxt = PH_NORMAL;
      end
    end
  end

  assign failed_nxt = failed_r | fail_set;
  assign fail_end   = failed_nxt | (phase_nxt != PH_NORMAL);
  assign pos_nxt    = pos_r + POS_W'(nb);

  // run record for the queue
  assign q_push       = accept && ((nb != '0) || in_last);
  assign q_run.b0     = b0;
  assign q_run.b1     = b1;
  assign q_run.b2     = b2;
  assign q_run.nb     = nb;
  assign q_run.eos    = in_last;
  assign q_run.failed = in_last && fail_end;
  assign q_run.base   = pos_r;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_out_capacity;
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_NORMAL;
      cp_r     <= '0;
      pos_r    <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        phase_r  <= PH_NORMAL;
        cp_r     <= '0;
        pos_r    <= '0;
        failed_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        cp_r     <= cp_nxt;
        pos_r    <= pos_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // string state is cleared after the closing byte
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (pos_r == '0 && !failed_r && phase_r == PH_NORMAL))
    else $error("string state not cleared after last byte");

  // a failed string stops producing bytes
  a_no_bytes_when_failed: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (nb == '0))
    else $error("bytes produced after failure");
`endif

endmodule

>>> design/jsu_queue.sv
// short queue of result runs between front and back end
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::run_t wr_run,
  input  logic          pop,
  output jsu_pkg::run_t rd_run,
  output logic          empty,
  output logic          full
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok, pop_ok;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_run  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_run;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // fill count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  // a lone push grows the fill count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow push");
`endif

endmodule

>>> design/jsu_back.sv
// back end: unrolls each run into result items behind an output register
module jsu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  jsu_pkg::run_t                q_run,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [jsu_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                         out_has_byte,
  output logic                         out_run_last,
  output logic                         out_end_of_string,
  output logic                         out_failed,
  output logic [jsu_pkg::COUNT_W-1:0]  out_count
);
  import jsu_pkg::*;

  logic [NB_W-1:0]    idx_r, idx_nxt;
  logic               valid_r;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic               has_r, has_nxt;
  logic               last_r, last_nxt;
  logic               eos_r, eos_nxt;
  logic               failed_r, failed_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               load;
  logic [POS_W-1:0]   sum;

  assign load  = !valid_r || out_ready;
  assign q_pop = load && !q_empty && last_nxt;

  // result selected by the index within the head run
  always_comb begin
    case (idx_r)
      2'd0:    data_nxt = q_run.b0;
      2'd1:    data_nxt = q_run.b1;
      default: data_nxt = q_run.b2;
    endcase
    has_nxt    = (q_run.nb != '0);
    last_nxt   = !has_nxt || (idx_r == q_run.nb - NB_W'(1));
    eos_nxt    = q_run.eos && last_nxt;
    failed_nxt = q_run.failed && eos_nxt;
    sum        = q_run.base + POS_W'(idx_r) + POS_W'(1);
    count_nxt  = has_nxt ? sum[COUNT_W-1:0] : q_run.base[COUNT_W-1:0];
    idx_nxt    = last_nxt ? '0 : idx_r + NB_W'(1);
  end

  // control: output valid and run index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= idx_nxt;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      data_r   <= data_nxt;
      has_r    <= has_nxt;
      last_r   <= last_nxt;
      eos_r    <= eos_nxt;
      failed_r <= failed_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_data_byte     = data_r;
  assign out_has_byte      = has_r;
  assign out_run_last      = last_r;
  assign out_end_of_string = eos_r;
  assign out_failed        = failed_r;
  assign out_count         = count_r;

`ifndef SYNTHESIS
  // the closing item is always the last of its run
  a_eos_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && eos_r) |-> last_r)
    else $error("end of string without run last");

  // an item without a byte only closes a string
  a_empty_is_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !has_r) |-> (eos_r && data_r == '0))
    else $error("byteless item that does not close the string");
`endif

endmodule

>>> design/json_string_unescaper_utf8.sv
// top level: json string unescaper with utf-8 output for \u escapes
// latency: the first result of an item passes through the run queue and then the output register
// throughput: one input item per cycle while the run queue is not full; the output register issues
// one result per cycle while out_ready is high, so an item that yields two or three bytes holds the
// output for one result per byte, and the run queue between decoder and output absorbs such bursts
// reset: synchronous active low; clears decode state, queue and output valid, capacity 8192
module json_string_unescaper_utf8 #(
  parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF,
  parameter int QUEUE_DEPTH  = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [jsu_pkg::CFG_W-1:0]    cfg_out_capacity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jsu_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [jsu_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                         out_has_byte,
  output logic                         out_run_last,
  output logic                         out_end_of_string,
  output logic                         out_failed,
  output logic [jsu_pkg::COUNT_W-1:0]  out_count
);
  import jsu_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  run_t wr_run, rd_run;

  // decoder
  jsu_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_out_capacity (cfg_out_capacity),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_run            (wr_run)
  );

  // run queue
  jsu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_run (wr_run),
    .pop    (q_pop),
    .rd_run (rd_run),
    .empty  (q_empty),
    .full   (q_full)
  );

  // result issue
  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_run             (rd_run),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_has_byte      (out_has_byte),
    .out_run_last      (out_run_last),
    .out_end_of_string (out_end_of_string),
    .out_failed        (out_failed),
    .out_count         (out_count)
  );

endmodule

>>> tb/sv/tb_json_string_unescaper_utf8.sv
// testbench for the json string unescaper: random and directed strings checked against a scoreboard
`timescale 1ns / 1ps

module tb_json_string_unescaper_utf8;
  import jsu_pkg::*;

  localparam int MAX_CAP     = MAX_CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 120;

  // one result of the block, as seen on the output channel
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        run_last;
    logic        end_of_string;
    logic        failed;
    logic [12:0] out_count;
  } result_t;

  typedef logic [7:0] byte_q_t[$];

  // hex digit value of a byte, -1 when it is not a hex digit
  function automatic int nibble_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // decodes accepted items on its own and checks the block's results in order
  class unescape_scoreboard;
    int unsigned capacity;
    int unsigned max_cap;
    phase_t      phase;
    logic [15:0] code_point;
    int unsigned wr_pos;
    bit          str_failed;
    result_t     decoded_q[$];
    result_t     run_q[$];
    int          errors;

    function new(int unsigned max_cap_i);
      max_cap    = max_cap_i;
      capacity   = CAP_RESET;
      errors     = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase      = PH_NORMAL;
      code_point = '0;
      wr_pos     = 0;
      str_failed = 1'b0;
    endfunction

    // one byte is always kept back for the terminator
    function bit room_for(int unsigned k);
      int unsigned lim;
      lim = (capacity > max_cap) ? max_cap : capacity;
      return (wr_pos + k) < lim;
    endfunction

    function void fail_string();
      str_failed = 1'b1;
      phase      = PH_NORMAL;
    endfunction

    function void emit(logic [7:0] b);
      result_t r;
      r = '0;
      wr_pos++;
      r.data_byte = b;
      r.has_byte  = 1'b1;
      r.out_count = 13'(wr_pos);
      run_q.push_back(r);
    endfunction

    // expected results of one accepted item
    function void decode_item(logic [7:0] b, logic last);
      int         hv;
      logic [7:0] simple;
      bit         is_simple;
      result_t    r;
      int         tail;
      run_q.delete();
      if (!str_failed) begin
        case (phase)
          PH_ESC: begin
            phase     = PH_NORMAL;
            is_simple = 1'b1;
            simple    = '0;
            case (b)
              CH_BSLASH: simple = CH_BSLASH;
              CH_QUOTE:  simple = CH_QUOTE;
              CH_SLASH:  simple = CH_SLASH;
              CH_N:      simple = CH_LF;
              CH_R:      simple = CH_CR;
              CH_T:      simple = CH_TAB;
              CH_B:      simple = CH_BS;
              CH_F:      simple = CH_FF;
              default:   is_simple = 1'b0;
            endcase
            if (is_simple) begin
              if (room_for(1)) emit(simple);
              else fail_string();
            end else if (b == CH_U) begin
              // \u reserves four bytes up front
              if (room_for(4)) begin
                phase      = PH_HEX0;
                code_point = '0;
              end else begin
                fail_string();
              end
            end else begin
              // unknown escape keeps the backslash
              if (room_for(2)) begin
                emit(CH_BSLASH);
                emit(b);
              end else begin
                fail_string();
              end
            end
          end
          PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
            hv = nibble_of(b);
            if (hv < 0) begin
              fail_string();
            end else begin
              code_point = {code_point[11:0], 4'(hv)};
              if (phase != PH_HEX3) begin
                phase = phase_t'(phase + 3'd1);
              end else begin
                phase = PH_NORMAL;
                // utf-8 encoding, no surrogate pairing
                if (code_point <= UTF_1B_MAX) begin
                  emit(code_point[7:0]);
                end else if (code_point <= UTF_2B_MAX) begin
                  emit(UTF_LEAD2 | {3'b000, code_point[10:6]});
                  emit(UTF_CONT | {2'b00, code_point[5:0]});
                end else begin
                  emit(UTF_LEAD3 | {4'b0000, code_point[15:12]});
                  emit(UTF_CONT | {2'b00, code_point[11:6]});
                  emit(UTF_CONT | {2'b00, code_point[5:0]});
                end
              end
            end
          end
          default: begin
            phase = PH_NORMAL;
            if (b == CH_BSLASH) phase = PH_ESC;
            else if (room_for(1)) emit(b);
            else fail_string();
          end
        endcase
      end
      // closing result of the string
      if (last) begin
        if (!str_failed && phase != PH_NORMAL) fail_string();
        if (run_q.size() == 0) begin
          r = '0;
          r.out_count = 13'(wr_pos);
          run_q.push_back(r);
        end
        tail = run_q.size() - 1;
        run_q[tail].end_of_string = 1'b1;
        run_q[tail].failed        = str_failed;
        clear_string();
      end
      if (run_q.size() > 0) run_q[run_q.size() - 1].run_last = 1'b1;
      foreach (run_q[i]) decoded_q.push_back(run_q[i]);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: byte %0h count %0d", got.data_byte, got.out_count);
        errors++;
        return;
      end
      exp_r = decoded_q.pop_front();
      if (got.data_byte !== exp_r.data_byte) begin
        $error("data_byte: expected %0h, got %0h", exp_r.data_byte, got.data_byte);
        errors++;
      end
      if (got.has_byte !== exp_r.has_byte) begin
        $error("has_byte: expected %0b, got %0b", exp_r.has_byte, got.has_byte);
        errors++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $error("run_last: expected %0b, got %0b", exp_r.run_last, got.run_last);
        errors++;
      end
      if (got.end_of_string !== exp_r.end_of_string) begin
        $error("end_of_string: expected %0b, got %0b", exp_r.end_of_string,
               got.end_of_string);
        errors++;
      end
      if (got.failed !== exp_r.failed) begin
        $error("failed: expected %0b, got %0b", exp_r.failed, got.failed);
        errors++;
      end
      if (got.out_count !== exp_r.out_count) begin
        $error("out_count: expected %0d, got %0d", exp_r.out_count, got.out_count);
        errors++;
      end
    endfunction
  endclass

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_we           = 1'b0;
  logic [CFG_W-1:0]    cfg_out_capacity = CAP_RESET;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_byte          = 8'h01;
  logic                in_last          = 1'b0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [BYTE_W-1:0]   out_data_byte;
  logic                out_has_byte;
  logic                out_run_last;
  logic                out_end_of_string;
  logic                out_failed;
  logic [COUNT_W-1:0]  out_count;

  unescape_scoreboard sb;
  int items_sent   = 0;
  int send_calm    = 0;
  int hold_at_item = -1;
  bit hold_req     = 1'b0;

  json_string_unescaper_utf8 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_out_capacity  (cfg_out_capacity),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_has_byte      (out_has_byte),
    .out_run_last      (out_run_last),
    .out_end_of_string (out_end_of_string),
    .out_failed        (out_failed),
    .out_count         (out_count)
  );

  always #1 clk = ~clk;

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    if ($urandom_range(0, 1) == 1) return 8'("a") + 8'(n) - 8'd10;
    return 8'("A") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] simple_esc_char();
    logic [7:0] set_c[8];
    set_c = '{CH_BSLASH, CH_QUOTE, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F};
    return set_c[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] unknown_esc_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b inside {CH_BSLASH, CH_QUOTE, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F, CH_U});
    return b;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (nibble_of(b) >= 0);
    return b;
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges[6];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 16'h7F));
      1:       return 16'($urandom_range(16'h80, 16'h7FF));
      2:       return 16'($urandom_range(16'h800, 16'hFFFF));
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  // mostly well formed strings, some noise, a minority broken at the end
  function automatic byte_q_t make_string();
    byte_q_t     q;
    int          n_tok;
    int          kind;
    logic [15:0] cp;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        q.push_back(plain_byte());
      end else if (kind < 50) begin
        q.push_back(CH_BSLASH);
        q.push_back(simple_esc_char());
      end else if (kind < 60) begin
        q.push_back(CH_BSLASH);
        q.push_back(unknown_esc_char());
      end else if (kind < 88) begin
        cp = pick_code_point();
        q.push_back(CH_BSLASH);
        q.push_back(CH_U);
        for (int k = 0; k < 4; k++) q.push_back(hex_char(cp[15 - 4 * k -: 4]));
      end else begin
        q.push_back(8'($urandom_range(1, 255)));
      end
    end
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      q.push_back(CH_BSLASH);
    end else if (kind < 12) begin
      q.push_back(CH_BSLASH);
      q.push_back(CH_U);
      repeat ($urandom_range(0, 3)) q.push_back(hex_char(4'($urandom_range(0, 15))));
    end else if (kind < 18) begin
      q.push_back(CH_BSLASH);
      q.push_back(CH_U);
      repeat ($urandom_range(0, 3)) q.push_back(hex_char(4'($urandom_range(0, 15))));
      q.push_back(bad_hex_char());
      repeat ($urandom_range(0, 3)) q.push_back(plain_byte());
    end
    return q;
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.decode_item(b, last);
    items_sent++;
    if (items_sent == hold_at_item) hold_req = 1'b1;
  endtask

  task automatic send_string(input byte_q_t q);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  task automatic send_random(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) send_string(make_string());
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] v);
    wait_idle(SETTLE);
    cfg_we           <= 1'b1;
    cfg_out_capacity <= v;
    @(posedge clk);
    sb.capacity = v;
    cfg_we <= 1'b0;
  endtask

  // result side: check accepted results, stall at random, one long hold-off on request
  initial begin : result_sink
    int      stall_left;
    int      calm_left;
    result_t got;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.data_byte     = out_data_byte;
        got.has_byte      = out_has_byte;
        got.run_last      = out_run_last;
        got.end_of_string = out_end_of_string;
        got.failed        = out_failed;
        got.out_count     = out_count;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0) stall_left = pick_gap(calm_left);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ends the run when nothing moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // stimulus: directed strings, then random phases at several capacities
  initial begin : stimulus
    byte_q_t s;
    sb = new(MAX_CAP);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes passed through
    s = '{8'h01, 8'hFF};
    send_string(s);
    // simple escape, then a two byte code point closing the string
    s = '{CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_U, "0", "7", "F", "f"};
    send_string(s);
    // three byte code point, then an unknown escape on the final byte
    s = '{CH_BSLASH, CH_U, "e", "2", "8", "2", CH_BSLASH, "q"};
    send_string(s);
    // trailing backslash
    s = '{CH_BSLASH};
    send_string(s);
    // bad hex digit, rest of the string discarded
    s = '{CH_BSLASH, CH_U, "1", "g", "x"};
    send_string(s);
    // string ends inside \u
    s = '{CH_BSLASH, CH_U, "0"};
    send_string(s);

    hold_at_item = items_sent + 30;
    send_random(80);

    set_capacity(14'd1);
    send_random(20);

    set_capacity(14'd5);
    send_random(50);

    set_capacity(14'd8192);
    hold_at_item = items_sent + 20;
    send_random(40);

    set_capacity(14'($urandom_range(6, 24)));
    send_random(40);

    wait_idle(4 * SETTLE);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
